// File: sv/bfba_pkg.sv
// bfba_pkg: types, codes and sizes shared by the best-fit block allocator
// depends on nothing; used by every module of the allocator
package bfba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EXACT    = 3'd2;
  localparam logic [2:0] ST_SPLIT    = 3'd3;
  localparam logic [2:0] ST_NOFIT    = 3'd4;
  localparam logic [2:0] ST_LISTED   = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] addr_in;
    logic [31:0] size_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_addr;
    logic [31:0] out_size;
    logic [3:0]  out_index;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_ALLOC,
    S_ROVER,
    S_LIST
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INSERT,
    CMD_ALLOC_STEP,
    CMD_ALLOC_END,
    CMD_ROVER_STEP,
    CMD_LIST_STEP,
    CMD_LIST_END
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic exact;
    logic cur_free;
  } dp_status_t;

endpackage

// File: sv/best_fit_block_allocator_core.sv
// best_fit_block_allocator_core: top level of the best-fit block allocator
// depends on bfba_pkg, bfba_ctrl and bfba_dpath
// insert gives one result; allocate gives one after scanning all n loaded blocks
// list: one result per free entry, at most one a cycle, the flagged last one after the scan
// a new item is taken only while not busy; an exact fit adds a rover search after the scan
// rst_n synchronous active low: table empty, rover 0, no result pending; receiver cannot stall
module best_fit_block_allocator_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bfba_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output bfba_pkg::out_item_t  out_item
);

  // command and status between sequencer and datapath
  bfba_pkg::cmd_t        cmd;
  bfba_pkg::dp_status_t  stat;

  // sequencer: one state per operation plus a rover state; scans step one table entry per cycle
  bfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_item.opcode),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // datapath: table, scan index, best candidate and result register
  bfba_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: sv/bfba_ctrl.sv
// bfba_ctrl: sequencing state machine of the block allocator
// depends on bfba_pkg; drives the datapath through cmd_t commands
module bfba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_opcode,
  input  bfba_pkg::dp_status_t  stat,
  output logic                  busy,
  output bfba_pkg::cmd_t        cmd
);

  bfba_pkg::state_t state_r;
  bfba_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = bfba_pkg::CMD_NONE;
    busy      = (state_r != bfba_pkg::S_IDLE);
    unique case (state_r)
      bfba_pkg::S_IDLE: begin
        if (start) begin
          cmd = bfba_pkg::CMD_LOAD;
          unique case (in_opcode)
            bfba_pkg::OP_INSERT: state_nxt = bfba_pkg::S_INSERT;
            bfba_pkg::OP_ALLOC:  state_nxt = bfba_pkg::S_ALLOC;
            bfba_pkg::OP_LIST:   state_nxt = bfba_pkg::S_LIST;
            default:             state_nxt = bfba_pkg::S_IDLE;
          endcase
        end
      end
      bfba_pkg::S_INSERT: begin
        cmd       = bfba_pkg::CMD_INSERT;
        state_nxt = bfba_pkg::S_IDLE;
      end
      bfba_pkg::S_ALLOC: begin
        if (stat.scan_done) begin
          cmd       = bfba_pkg::CMD_ALLOC_END;
          state_nxt = (stat.found && stat.exact) ? bfba_pkg::S_ROVER : bfba_pkg::S_IDLE;
        end else begin
          cmd = bfba_pkg::CMD_ALLOC_STEP;
        end
      end
      bfba_pkg::S_ROVER: begin
        if (stat.scan_done) begin
          state_nxt = bfba_pkg::S_IDLE;
        end else begin
          cmd = bfba_pkg::CMD_ROVER_STEP;
          if (stat.cur_free) begin
            state_nxt = bfba_pkg::S_IDLE;
          end
        end
      end
      bfba_pkg::S_LIST: begin
        if (stat.scan_done) begin
          cmd       = bfba_pkg::CMD_LIST_END;
          state_nxt = bfba_pkg::S_IDLE;
        end else begin
          cmd = bfba_pkg::CMD_LIST_STEP;
        end
      end
      default: state_nxt = bfba_pkg::S_IDLE;
    endcase
  end

endmodule

// File: sv/bfba_dpath.sv
// bfba_dpath: block table, scan index, best-candidate and result registers
// depends on bfba_pkg; executes one cmd_t command per cycle
module bfba_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfba_pkg::in_item_t    in_item,
  input  bfba_pkg::cmd_t        cmd,
  output bfba_pkg::dp_status_t  stat,
  output logic                  out_valid,
  output bfba_pkg::out_item_t   out_item
);

  localparam int IW = bfba_pkg::IDX_W;
  localparam int CW = bfba_pkg::CNT_W;

  // table storage
  logic [31:0]                   addr_r [bfba_pkg::MAX_BLOCKS];
  logic [31:0]                   len_r  [bfba_pkg::MAX_BLOCKS];
  logic [bfba_pkg::MAX_BLOCKS-1:0] taken_r;
  logic [CW-1:0]                 cnt_r;
  logic [IW-1:0]                 rover_r;

  // scan state
  bfba_pkg::in_item_t            in_r;
  logic [IW-1:0]                 idx_r;
  logic [CW-1:0]                 step_r;
  logic                          found_r;
  logic [IW-1:0]                 best_idx_r;
  logic [31:0]                   best_len_r;
  logic [31:0]                   best_addr_r;
  logic                          pend_valid_r;
  logic [IW-1:0]                 pend_idx_r;
  logic [31:0]                   pend_addr_r;
  logic [31:0]                   pend_len_r;

  logic                          out_valid_r;
  bfba_pkg::out_item_t           out_r;
  bfba_pkg::out_item_t           out_nxt;
  logic                          out_set;

  logic [31:0]                   cur_len;
  logic [31:0]                   cur_addr;
  logic                          cur_free;
  logic [CW-1:0]                 idx_p1;
  logic [IW-1:0]                 idx_wrap;
  logic [CW-1:0]                 best_p1;
  logic [IW-1:0]                 best_wrap;
  logic                          fits;
  logic                          full;
  logic                          exact;
  logic [31:0]                   split_len;
  logic [IW-1:0]                 wr_idx;

  assign cur_len   = len_r[idx_r];
  assign cur_addr  = addr_r[idx_r];
  assign cur_free  = !taken_r[idx_r];
  assign idx_p1    = CW'(idx_r) + CW'(1);
  assign idx_wrap  = (idx_p1 == cnt_r) ? '0 : IW'(idx_p1);
  assign best_p1   = CW'(best_idx_r) + CW'(1);
  assign best_wrap = (best_p1 == cnt_r) ? '0 : IW'(best_p1);
  assign full      = (cnt_r == CW'(bfba_pkg::MAX_BLOCKS));
  assign exact     = (best_len_r == in_r.size_in);
  assign split_len = best_len_r - in_r.size_in;
  assign wr_idx    = IW'(cnt_r);
  // free, large enough, and strictly smaller than the best so far
  assign fits      = cur_free && (cur_len >= in_r.size_in) &&
                     (!found_r || (cur_len < best_len_r));

  assign stat.scan_done = (step_r == cnt_r);
  assign stat.found     = found_r;
  assign stat.exact     = exact;
  assign stat.cur_free  = cur_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // result word for the current command
  always_comb begin
    out_set = 1'b0;
    out_nxt = '0;
    out_nxt.last = 1'b1;
    unique case (cmd)
      bfba_pkg::CMD_INSERT: begin
        out_set = 1'b1;
        if (full) begin
          out_nxt.status = bfba_pkg::ST_FULL;
        end else begin
          out_nxt.status    = bfba_pkg::ST_INSERTED;
          out_nxt.out_addr  = in_r.addr_in;
          out_nxt.out_size  = in_r.size_in;
          out_nxt.out_index = 4'(cnt_r);
        end
      end
      bfba_pkg::CMD_ALLOC_END: begin
        out_set = 1'b1;
        if (!found_r) begin
          out_nxt.status = bfba_pkg::ST_NOFIT;
        end else begin
          out_nxt.status    = exact ? bfba_pkg::ST_EXACT : bfba_pkg::ST_SPLIT;
          out_nxt.out_addr  = best_addr_r;
          out_nxt.out_size  = exact ? in_r.size_in : split_len;
          out_nxt.out_index = 4'(best_idx_r);
        end
      end
      bfba_pkg::CMD_LIST_STEP: begin
        // a pending entry is sent once another free entry shows it is not last
        out_set           = cur_free && pend_valid_r;
        out_nxt.status    = bfba_pkg::ST_LISTED;
        out_nxt.out_addr  = pend_addr_r;
        out_nxt.out_size  = pend_len_r;
        out_nxt.out_index = 4'(pend_idx_r);
        out_nxt.last      = 1'b0;
      end
      bfba_pkg::CMD_LIST_END: begin
        out_set = 1'b1;
        if (pend_valid_r) begin
          out_nxt.status    = bfba_pkg::ST_LISTED;
          out_nxt.out_addr  = pend_addr_r;
          out_nxt.out_size  = pend_len_r;
          out_nxt.out_index = 4'(pend_idx_r);
        end else begin
          out_nxt.status = bfba_pkg::ST_EMPTY;
        end
      end
      default: out_set = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rover_r      <= '0;
      taken_r      <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_set;
      unique case (cmd)
        bfba_pkg::CMD_LOAD: begin
          found_r      <= 1'b0;
          pend_valid_r <= 1'b0;
        end
        bfba_pkg::CMD_INSERT: begin
          if (!full) begin
            cnt_r           <= cnt_r + CW'(1);
            rover_r         <= '0;
            taken_r[wr_idx] <= 1'b0;
          end
        end
        bfba_pkg::CMD_ALLOC_STEP: begin
          if (fits) begin
            found_r <= 1'b1;
          end
        end
        bfba_pkg::CMD_ALLOC_END: begin
          if (found_r && exact) begin
            taken_r[best_idx_r] <= 1'b1;
            rover_r             <= best_wrap;
          end
        end
        bfba_pkg::CMD_ROVER_STEP: begin
          if (cur_free) begin
            rover_r <= idx_r;
          end
        end
        bfba_pkg::CMD_LIST_STEP: begin
          if (cur_free) begin
            pend_valid_r <= 1'b1;
          end
        end
        bfba_pkg::CMD_LIST_END, bfba_pkg::CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_set) begin
      out_r <= out_nxt;
    end
    unique case (cmd)
      bfba_pkg::CMD_LOAD: begin
        in_r   <= in_item;
        idx_r  <= rover_r;
        step_r <= '0;
      end
      bfba_pkg::CMD_INSERT: begin
        if (!full) begin
          addr_r[wr_idx] <= in_r.addr_in;
          len_r[wr_idx]  <= in_r.size_in;
        end
      end
      bfba_pkg::CMD_ALLOC_STEP: begin
        if (fits) begin
          best_idx_r  <= idx_r;
          best_len_r  <= cur_len;
          best_addr_r <= cur_addr;
        end
        idx_r  <= idx_wrap;
        step_r <= step_r + CW'(1);
      end
      bfba_pkg::CMD_ALLOC_END: begin
        if (found_r) begin
          if (exact) begin
            idx_r  <= best_wrap;
            step_r <= '0;
          end else begin
            len_r[best_idx_r] <= split_len;
          end
        end
      end
      bfba_pkg::CMD_ROVER_STEP: begin
        idx_r  <= idx_wrap;
        step_r <= step_r + CW'(1);
      end
      bfba_pkg::CMD_LIST_STEP: begin
        if (cur_free) begin
          pend_idx_r  <= idx_r;
          pend_addr_r <= cur_addr;
          pend_len_r  <= cur_len;
        end
        idx_r  <= idx_wrap;
        step_r <= step_r + CW'(1);
      end
      bfba_pkg::CMD_LIST_END, bfba_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/bfba_checker.sv
// bfba_checker: port-level assertions for the best-fit block allocator
// depends on bfba_pkg; bound to best_fit_block_allocator_core below
module bfba_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input bfba_pkg::in_item_t   in_item,
  input logic                 out_valid,
  input bfba_pkg::out_item_t  out_item
);

  // every result comes from work started by an earlier transfer
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobed without a busy cycle before it");

  // a valid operation keeps the block busy after its transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_item.opcode == bfba_pkg::OP_INSERT) ||
                        (in_item.opcode == bfba_pkg::OP_ALLOC) ||
                        (in_item.opcode == bfba_pkg::OP_LIST))) |=> busy)
    else $error("block not busy after an accepted operation");

  // only listed entries can be followed by more results
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != bfba_pkg::ST_LISTED)) |-> out_item.last)
    else $error("single result without last flag");

  // failure answers carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_item.status == bfba_pkg::ST_FULL) ||
                   (out_item.status == bfba_pkg::ST_NOFIT) ||
                   (out_item.status == bfba_pkg::ST_EMPTY))) |->
    ((out_item.out_addr == '0) && (out_item.out_size == '0) && (out_item.out_index == '0)))
    else $error("failure result with nonzero payload");

endmodule

bind best_fit_block_allocator_core bfba_checker u_bfba_checker (.*);
